[hdl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, suspended while reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pmaf_pkg.sv]
package pmaf_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned PresW    = 16;
  localparam int unsigned FlowW    = 17;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 56;

  // Integer square root of a 16-bit magnitude: one result bit per step.
  localparam int unsigned RootW     = PresW / 2;
  localparam int unsigned SqrtSteps = PresW / 2;
  localparam int unsigned SqrtCntW  = $clog2(SqrtSteps);

  localparam logic [CfgW-1:0] AdcGainRst      = 16'd3267;
  localparam logic [CfgW-1:0] PressureBiasRst = 16'hDF60;  // -8352
  localparam logic [CfgW-1:0] FlowCoeffRst    = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAdcGain      = 2'd0,
    CfgPressureBias = 2'd1,
    CfgFlowCoeff    = 2'd2
  } cfg_idx_e;

  // Commands from the sequencer to the datapath, one per processing step.
  typedef struct packed {
    logic accept;     // latch the sample, read the oldest ring entry
    logic scale;      // sample * gain
    logic raw;        // bias, saturate, ring write, running sum update
    logic filt;       // select filtered pressure, start the root
    logic sqrt_step;  // one bit of the square root
    logic fmul;       // root * flow coefficient
    logic load_out;   // move the finished result into the output register
  } cmd_t;

endpackage

[hdl/pmaf_ctrl.sv]
module pmaf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output pmaf_pkg::cmd_t  cmd_o
);
  import pmaf_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StScale = 7'b0000010,
    StRaw   = 7'b0000100,
    StFilt  = 7'b0001000,
    StSqrt  = 7'b0010000,
    StFmul  = 7'b0100000,
    StFlow  = 7'b1000000
  } state_e;

  localparam logic [SqrtCntW-1:0] SqrtLast = SqrtCntW'(SqrtSteps - 1);

  state_e              state_q, state_d;
  logic [SqrtCntW-1:0] cnt_q, cnt_d;
  logic                m_valid_q, m_valid_d;
  logic                out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StScale;
        end
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StRaw;
      end
      StRaw: begin
        cmd_o.raw = 1'b1;
        state_d   = StFilt;
      end
      StFilt: begin
        cmd_o.filt = 1'b1;
        cnt_d      = '0;
        state_d    = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == SqrtLast) begin
          state_d = StFmul;
        end
      end
      StFmul: begin
        cmd_o.fmul = 1'b1;
        state_d    = StFlow;
      end
      StFlow: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

[hdl/pmaf_dp.sv]
module pmaf_dp #(
  parameter int unsigned WINDOW_LENGTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pmaf_pkg::cmd_t                  cmd_i,
  input  logic [pmaf_pkg::SampleW-1:0]    sample_i,
  input  logic                            cfg_we_i,
  input  logic [pmaf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pmaf_pkg::CfgW-1:0]       cfg_wdata_i,
  output logic [pmaf_pkg::OutDataW-1:0]   out_data_o,
  output logic                            out_ready_flag_o
);
  import pmaf_pkg::*;

  localparam int unsigned SlotW  = $clog2(WINDOW_LENGTH);
  localparam int unsigned SumW   = PresW + SlotW;
  localparam int unsigned ProdW  = SampleW + CfgW;
  localparam int unsigned ScaleW = ProdW - 8 + 2;
  localparam int unsigned FprodW = RootW + CfgW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW_LENGTH - 1);
  localparam logic signed [ScaleW-1:0] PresMax = ScaleW'(32767);
  localparam logic signed [ScaleW-1:0] PresMin = -ScaleW'(32768);

  // Configuration registers.
  logic [CfgW-1:0] gain_q, bias_q, coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= AdcGainRst;
      bias_q  <= PressureBiasRst;
      coeff_q <= FlowCoeffRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgAdcGain:      gain_q  <= cfg_wdata_i;
        CfgPressureBias: bias_q  <= cfg_wdata_i;
        CfgFlowCoeff:    coeff_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window ring. Slots are filled in order from zero, so before the first
  // wrap the slot about to be overwritten has never been written and reads
  // as zero through the full flag.
  logic [PresW-1:0] ring_mem [WINDOW_LENGTH];
  logic [PresW-1:0] old_q;
  logic [PresW-1:0] raw_d;
  logic [SlotW-1:0] slot_q;
  logic             full_q;
  logic signed [SumW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      old_q <= ring_mem[slot_q];
    end
    if (cmd_i.raw) begin
      ring_mem[slot_q] <= raw_d;
    end
  end

  // Scaling.
  logic [SampleW-1:0] sample_q;
  logic [ProdW-1:0]   prod_q;
  logic signed [ScaleW-1:0] scaled;
  logic [PresW-1:0]   raw_q, old_val;

  assign scaled = signed'({2'b00, prod_q[ProdW-1:8]})
                + {{(ScaleW-CfgW){bias_q[CfgW-1]}}, bias_q};

  always_comb begin
    if (scaled > PresMax) begin
      raw_d = 16'h7FFF;
    end else if (scaled < PresMin) begin
      raw_d = 16'h8000;
    end else begin
      raw_d = scaled[PresW-1:0];
    end
  end

  assign old_val = full_q ? old_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.scale) begin
      prod_q <= ProdW'(sample_q) * ProdW'(gain_q);
    end
    if (cmd_i.raw) begin
      raw_q <= raw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      slot_q <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.raw) begin
      sum_q <= sum_q - {{(SumW-PresW){old_val[PresW-1]}}, old_val}
                     + {{(SumW-PresW){raw_d[PresW-1]}}, raw_d};
      if (slot_q == LastSlot) begin
        slot_q <= '0;
        full_q <= 1'b1;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // Filtered pressure and the bit-serial square root of its magnitude.
  logic signed [SumW-1:0] avg;
  logic [PresW-1:0] filt_d, filt_q, mag_d, rad_q;
  logic             neg_q;
  logic [RootW-1:0] root_q;
  logic [RootW+1:0] rem_q;
  logic [RootW+3:0] rem_sh, trial, rem_sub;
  logic             take;

  assign avg    = sum_q >>> SlotW;
  assign filt_d = full_q ? avg[PresW-1:0] : raw_q;
  assign mag_d  = filt_d[PresW-1] ? (~filt_d + 1'b1) : filt_d;

  assign rem_sh  = {rem_q, rad_q[PresW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign take    = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.filt) begin
      filt_q <= filt_d;
      neg_q  <= filt_d[PresW-1];
      rad_q  <= mag_d;
      root_q <= '0;
      rem_q  <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[PresW-3:0], 2'b00};
      root_q <= {root_q[RootW-2:0], take};
      rem_q  <= take ? rem_sub[RootW+1:0] : rem_sh[RootW+1:0];
    end
  end

  // Flow: the root is at most 181, so root * coeff >> 8 stays below 46340
  // and needs no saturation.
  logic [FprodW-1:0] fprod_q;
  logic [FlowW-1:0]  fmag, flow;

  assign fmag = {1'b0, fprod_q[FprodW-1:8]};
  assign flow = neg_q ? (~fmag + 1'b1) : fmag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fmul) begin
      fprod_q <= FprodW'(root_q) * FprodW'(coeff_q);
    end
    if (cmd_i.load_out) begin
      out_data_o       <= {{(OutDataW-2*PresW-FlowW){1'b0}}, flow, filt_q, raw_q};
      out_ready_flag_o <= full_q;
    end
  end

endmodule

[hdl/pressure_moving_average_flow_top.sv]
// Channel   Dir  Width  Contents (lowest bits first)
// s_axis    in   16     tdata: adc_sample[9:0], zero padding
// m_axis    out  56/1   tdata: raw_pressure, filtered_pressure, flow_rate, zeros;
//                       tuser: filter_ready
// cfg       in   2/16   register index, write data; written when cfg_we_i is high
//
// After its input transfer a sample passes through one multiply for scaling, a step
// for bias, saturation and the running-sum update, a step to pick the filtered
// value, eight steps of the square-root unit, one multiply for flow and the load
// of the output register, which waits while the output holds an untaken result.
// The block takes no new sample while one is in progress.
// A new sample is taken once the previous one has been handed to the output
// register, so a result waiting on a stalled consumer does not block the input.
// If the output stays full the block holds its finished result and stops taking
// samples. Reset clears the window, running sum and registers to their defaults.
// WINDOW_LENGTH must be a power of two; the average is an arithmetic shift.
module pressure_moving_average_flow_top #(
  parameter int unsigned WINDOW_LENGTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pmaf_pkg::InDataW-1:0]  s_axis_tdata,   // adc_sample, zeros
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pmaf_pkg::OutDataW-1:0] m_axis_tdata,   // raw, filtered, flow, zeros
  output logic                          m_axis_tuser,   // filter_ready
  input  logic                          cfg_we_i,
  input  logic [pmaf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pmaf_pkg::CfgW-1:0]     cfg_wdata_i
);
  import pmaf_pkg::*;

  cmd_t cmd;

  // Sequencer: steps each sample through the datapath and owns both handshakes.
  pmaf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  // Datapath: scaling, window ring and running sum, square root, flow, and
  // the output register.
  pmaf_dp #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sample_i         (s_axis_tdata[SampleW-1:0]),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_data_o       (m_axis_tdata),
    .out_ready_flag_o (m_axis_tuser)
  );

endmodule

[hdl/pmaf_checker.sv]
`include "assert_macros.svh"

module pmaf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [pmaf_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pmaf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          cfg_we_i,
  input logic [pmaf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [pmaf_pkg::CfgW-1:0]     cfg_wdata_i
);
  import pmaf_pkg::*;

  // A stalled result keeps its contents.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")

  // One sample at a time: after an input transfer the input is busy.
  `ASSERT_RST(a_in_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while a sample is in progress")

  // Zero filtered pressure gives zero flow.
  `ASSERT_RST(a_zero_flow, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[31:16] == 16'd0) |-> (m_axis_tdata[48:32] == 17'd0), "nonzero flow at zero pressure")

  // Non-negative filtered pressure never gives negative flow.
  `ASSERT_RST(a_flow_sign, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[31] |-> !m_axis_tdata[48], "flow sign disagrees with pressure")

  // An edge seen in reset leaves no result showing at the following edge.
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind pressure_moving_average_flow_top pmaf_checker u_pmaf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_wdata_i   (cfg_wdata_i)
);

[bench/pmaf_flow_checker.sv]
module pmaf_flow_checker
  import pmaf_pkg::*;
#(
  parameter int unsigned WindowLen = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  input  logic                m_axis_tuser_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotW = $clog2(WindowLen);
  localparam int unsigned SumW  = PresW + SlotW;

  typedef struct packed {
    logic signed [PresW-1:0] raw;
    logic signed [PresW-1:0] filt;
    logic signed [FlowW-1:0] flow;
    logic                    ready;
  } flow_result_t;

  // Shadow copy of the registers and of the averaging window.
  logic        [CfgW-1:0]  adc_gain;
  logic signed [CfgW-1:0]  pressure_bias;
  logic        [CfgW-1:0]  flow_coeff;
  logic signed [PresW-1:0] pressure_ring [WindowLen];
  logic signed [SumW-1:0]  ring_sum;
  logic        [SlotW-1:0] next_slot;
  logic                    window_filled;

  flow_result_t expected_results [$];
  flow_result_t expected_r;
  flow_result_t observed_r;
  int unsigned  mismatches;

  // Floor square root, one result bit at a time from the top.
  function automatic logic [RootW-1:0] floor_root(input logic [PresW-1:0] mag);
    logic [RootW-1:0] root;
    logic [RootW-1:0] trial;
    root = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      trial = root | (RootW'(1) << b);
      if (32'(trial) * 32'(trial) <= 32'(mag)) root = trial;
    end
    return root;
  endfunction

  // Scales one sample, pushes it through the window and derives the flow.
  function automatic flow_result_t advance_window(input logic [SampleW-1:0] adc_sample);
    flow_result_t                res;
    logic [SampleW+CfgW-1:0]     product;
    int                          scaled;
    logic [PresW-1:0]            mag;
    logic [RootW-1:0]            root;
    int                          flow_mag;
    product = adc_sample * adc_gain;
    scaled  = int'(product >> 8) + int'(pressure_bias);
    if (scaled > 32767) begin
      res.raw = 16'sh7FFF;
    end else if (scaled < -32768) begin
      res.raw = 16'sh8000;
    end else begin
      res.raw = PresW'(scaled);
    end

    ring_sum = ring_sum - pressure_ring[next_slot] + res.raw;
    pressure_ring[next_slot] = res.raw;
    if (next_slot == SlotW'(WindowLen - 1)) window_filled = 1'b1;
    next_slot = next_slot + 1'b1;

    // An arithmetic shift of the sum rounds the average toward minus infinity.
    res.filt = window_filled ? PresW'(ring_sum >>> SlotW) : res.raw;

    res.flow = '0;
    if (res.filt != 0) begin
      mag      = res.filt[PresW-1] ? ~res.filt + 1'b1 : res.filt;
      root     = floor_root(mag);
      flow_mag = (int'(root) * int'(flow_coeff)) >> 8;
      if (flow_mag > 65535) flow_mag = 65535;
      res.flow = res.filt[PresW-1] ? FlowW'(-flow_mag) : FlowW'(flow_mag);
    end
    res.ready = window_filled;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_gain      = AdcGainRst;
      pressure_bias = PressureBiasRst;
      flow_coeff    = FlowCoeffRst;
      for (int i = 0; i < WindowLen; i++) pressure_ring[i] = '0;
      ring_sum      = '0;
      next_slot     = '0;
      window_filled = 1'b0;
      expected_results.delete();
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        observed_r.raw   = m_axis_tdata_i[PresW-1:0];
        observed_r.filt  = m_axis_tdata_i[2*PresW-1:PresW];
        observed_r.flow  = m_axis_tdata_i[2*PresW+FlowW-1:2*PresW];
        observed_r.ready = m_axis_tuser_i;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result raw %0d filtered %0d flow %0d ready %0b",
                     $realtime, observed_r.raw, observed_r.filt, observed_r.flow,
                     observed_r.ready);
          end
        end else begin
          expected_r = expected_results.pop_front();
          if (observed_r.raw !== expected_r.raw || observed_r.filt !== expected_r.filt ||
              observed_r.flow !== expected_r.flow || observed_r.ready !== expected_r.ready) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch raw %0d/%0d filtered %0d/%0d flow %0d/%0d ready %0b/%0b",
                       $realtime, expected_r.raw, observed_r.raw, expected_r.filt,
                       observed_r.filt, expected_r.flow, observed_r.flow,
                       expected_r.ready, observed_r.ready);
            end
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results.push_back(advance_window(s_axis_tdata_i[SampleW-1:0]));
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgAdcGain:      adc_gain      = cfg_wdata_i;
          CfgPressureBias: pressure_bias = cfg_wdata_i;
          CfgFlowCoeff:    flow_coeff    = cfg_wdata_i;
          default: ;
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

[bench/pressure_moving_average_flow_top_tb.sv]
module pressure_moving_average_flow_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmaf_pkg::*;

  // The block keeps a 16-deep window; the checker mirrors that depth.
  localparam int unsigned WindowLen     = 16;
  // How long the consumer refuses results during the backpressure phase.
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 62;
  // Index 3 names no register; the block must ignore writes to it.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;

  int unsigned fail_count;
  int unsigned pending;

  // Knobs shared by the sample source and the result sink.
  logic             src_idle_en  = 1'b1;
  logic             sink_idle_en = 1'b1;
  logic             hold_req     = 1'b0;
  logic [SampleW-1:0] last_sample = '0;

  pressure_moving_average_flow_top #(
    .WINDOW_LENGTH(WindowLen)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // The checker sees every transfer and register write on the pins and keeps its
  // own window model; it reports the mismatch count and the results still owed.
  pmaf_flow_checker #(
    .WindowLen(WindowLen)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes. 5 ms leaves a wide margin over
  // the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result sink. It mostly accepts, drops tready for random bursts, and once on
  // request refuses results for a long counted stretch so the block backs up.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        hold_req      <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // Offers one sample and returns right after the edge that completes its transfer.
  // tvalid stays high afterwards, so back-to-back samples need no extra edge.
  task automatic push_sample(input logic [SampleW-1:0] adc_sample);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(adc_sample);
    last_sample    = adc_sample;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // A single register write; the enable drops on the following edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgW-1:0] gain, input logic [CfgW-1:0] bias,
                              input logic [CfgW-1:0] coeff);
    write_reg(CfgAdcGain, gain);
    write_reg(CfgPressureBias, bias);
    write_reg(CfgFlowCoeff, coeff);
  endtask

  // Stops offering samples and waits until every result has been handed over, then
  // gives the pipeline some slack before registers are touched again.
  // The first edge lets the checker count the transfer that just completed.
  task automatic wait_flow_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Samples are mostly uniform, with runs that wander near the previous value so
  // the average settles, and a share of the two converter rails.
  function automatic logic [SampleW-1:0] next_sample(input logic [SampleW-1:0] prev);
    int pick;
    int walk;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    if (pick < 45) begin
      walk = int'(prev) + int'($urandom_range(0, 64)) - 32;
      if (walk < 0) walk = 0;
      if (walk > 1023) walk = 1023;
      return SampleW'(walk);
    end
    return SampleW'($urandom_range(0, 1023));
  endfunction

  initial begin
    logic [CfgW-1:0] gain_v;
    logic [CfgW-1:0] bias_v;
    logic [CfgW-1:0] coeff_v;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset values. Sixteen samples fill the window exactly,
    // so the last one shows the switch from raw to averaged pressure. Sample zero
    // gives a negative pressure, so the flow comes out negated.
    push_sample('0);
    push_sample('1);
    push_sample(10'h155);
    push_sample(10'h2AA);
    for (int i = 0; i < SampleW; i++) push_sample(SampleW'(1) << i);
    push_sample(10'h3FE);
    push_sample('0);
    wait_flow_idle();

    // Largest gain and bias: the scaled pressure runs past the top and saturates.
    program_regs(16'hFFFF, 16'h7FFF, 16'hFFFF);
    push_sample('1);
    push_sample('0);
    push_sample(10'h200);
    wait_flow_idle();

    // Zero gain with the most negative bias pins raw pressure at the bottom rail.
    // A write to the unused index in between must change nothing.
    program_regs(16'h0000, 16'h8000, 16'hFFFF);
    write_reg(CfgUnused, 16'h1234);
    push_sample('0);
    push_sample('1);
    wait_flow_idle();

    // Random part, one register setting per phase. Each phase ends with the source
    // paused until every result has come back.
    for (int ph = 0; ph < NumPhases; ph++) begin
      gain_v  = CfgW'($urandom_range(0, 65535));
      bias_v  = CfgW'($urandom_range(0, 65535));
      coeff_v = CfgW'($urandom_range(0, 65535));
      case (ph)
        // Zero gain and bias: once the window holds only zeros the filtered
        // pressure is zero and the flow must be zero as well.
        1: begin
          gain_v = '0;
          bias_v = '0;
        end
        2: begin
          gain_v  = '0;
          bias_v  = 16'h8000;
          coeff_v = '1;
        end
        3: begin
          gain_v = '1;
          bias_v = 16'h7FFF;
        end
        4: begin
          gain_v  = '1;
          bias_v  = 16'h8000;
          coeff_v = 16'd1;
        end
        // Moderate gain keeps the pressure inside the range most of the time.
        5: gain_v = CfgW'($urandom_range(0, 2047));
        default: ;
      endcase
      program_regs(gain_v, bias_v, coeff_v);
      if (ph == 6) write_reg(CfgUnused, CfgW'($urandom_range(0, 65535)));

      // Backpressure phase: the sink stops for a long time while the first twenty
      // samples come without gaps, so the output and the pipeline fill and tready drops.
      if (ph == 3) begin
        hold_req   <= 1'b1;
        src_idle_en = 1'b0;
      end
      // The last phase runs at full rate on both sides.
      if (ph == NumPhases - 1) begin
        sink_idle_en <= 1'b0;
        src_idle_en   = 1'b0;
      end

      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (ph == 3 && k == 20) src_idle_en = 1'b1;
        push_sample(next_sample(last_sample));
      end
      wait_flow_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/pmaf_pkg.sv
hdl/pmaf_ctrl.sv
hdl/pmaf_dp.sv
hdl/pressure_moving_average_flow_top.sv
hdl/pmaf_checker.sv
bench/pmaf_flow_checker.sv
bench/pressure_moving_average_flow_top_tb.sv
